// ===== design/mtf_pkg.sv =====
// mtf_pkg: shared widths, defaults and the token control struct for the
// move-to-front encoder. Used by the channel interfaces and every design module.
`default_nettype none

package mtf_pkg;

  localparam int SYMBOL_W          = 7;
  localparam int RANK_W            = 7;
  localparam int ALPHABET_SIZE_DEF = 128;

  // control part of a token walking down the cell chain
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              found;
    logic [RANK_W-1:0] rank;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== design/mtf_if.sv =====
// mtf_if: valid/ready channel interfaces of the move-to-front encoder.
// Depends on mtf_pkg for the payload widths.
`default_nettype none

interface mtf_sym_if;
  logic                         valid;
  logic                         ready;
  logic [mtf_pkg::SYMBOL_W-1:0] symbol;
  logic                         last_of_message;

  modport source (output valid, output symbol, output last_of_message, input ready);
  modport sink   (input valid, input symbol, input last_of_message, output ready);
endinterface

interface mtf_rank_if;
  logic                       valid;
  logic                       ready;
  logic [mtf_pkg::RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

`default_nettype wire

// ===== design/mtf_cell.sv =====
// mtf_cell: one list entry of the move-to-front chain; matches the passing
// token, shifts the list entry back and registers the token for its neighbor. Uses mtf_pkg.
`default_nettype none

module mtf_cell #(
  parameter int SYM_W = 7,
  parameter int INDEX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire mtf_pkg::ctrl_t        ctrl_in,
  input  wire logic      [SYM_W-1:0] sym_in,
  input  wire logic      [SYM_W-1:0] carry_in,
  output mtf_pkg::ctrl_t             ctrl_out,
  output logic           [SYM_W-1:0] sym_out,
  output logic           [SYM_W-1:0] carry_out
);

  logic           [SYM_W-1:0] entry;
  logic           [SYM_W-1:0] entry_next;
  mtf_pkg::ctrl_t             ctrl_next;
  logic                       hit;

  assign hit = (entry == sym_in);

  always_comb begin
    ctrl_next  = ctrl_in;
    entry_next = entry;
    if (ctrl_in.valid) begin
      if (!ctrl_in.found) begin
        // entry takes the value shifted from ahead (or the symbol itself at the front)
        entry_next = carry_in;
        if (hit) begin
          ctrl_next.found = 1'b1;
          ctrl_next.rank  = mtf_pkg::RANK_W'(INDEX);
        end
      end
      if (ctrl_in.last) begin
        entry_next = SYM_W'(INDEX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry    <= SYM_W'(INDEX);
      ctrl_out <= '0;
    end else if (advance) begin
      entry    <= entry_next;
      ctrl_out <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sym_out   <= sym_in;
      carry_out <= entry;
    end
  end

endmodule

`default_nettype wire

// ===== design/mtf_out_buf.sv =====
// mtf_out_buf: two-entry result buffer at the end of the cell chain; its
// registered fill level gates the chain. Uses mtf_pkg and mtf_rank_if.
`default_nettype none

module mtf_out_buf (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [mtf_pkg::RANK_W-1:0] push_rank,
  output logic                            room,
  mtf_rank_if.source                      ranks
);

  logic [1:0]                 count;
  logic [mtf_pkg::RANK_W-1:0] slot0;
  logic [mtf_pkg::RANK_W-1:0] slot1;
  logic                       pop;

  assign room        = (count != 2'd2);
  assign pop         = (count != 2'd0) && ranks.ready;
  assign ranks.valid = (count != 2'd0);
  assign ranks.rank  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // push only arrives while count is below two
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          slot0 <= push_rank;
        end else begin
          slot1 <= push_rank;
        end
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_rank;
        end else begin
          slot0 <= slot1;
          slot1 <= push_rank;
        end
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/move_to_front_encoder.sv =====
// move_to_front_encoder: top level; a chain of mtf_cell instances holding the
// list, followed by mtf_out_buf. Uses mtf_pkg, mtf_sym_if and mtf_rank_if.
//
//   channel   kind          payload
//   symbols   sink          symbol[6:0], last_of_message
//   ranks     source        rank[6:0]
//
// one transaction per cycle while the result buffer has room; each symbol walks one
// cell per advancing cycle through all ALPHABET_SIZE cells before its rank enters mtf_out_buf.
// reset puts every cell back to identity order in the same cycle.
// the chain halts as a whole only while both result buffer slots are full;
// one waiting result does not stop input.
`default_nettype none

module move_to_front_encoder #(
  parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mtf_sym_if.sink    symbols,
  mtf_rank_if.source ranks
);

  localparam int SYM_W = $clog2(ALPHABET_SIZE);

  mtf_pkg::ctrl_t             ctrl  [0:ALPHABET_SIZE];
  logic           [SYM_W-1:0] sym   [0:ALPHABET_SIZE];
  logic           [SYM_W-1:0] carry [0:ALPHABET_SIZE];
  logic                       advance;
  logic                       sym_ok;
  logic [SYM_W+mtf_pkg::SYMBOL_W-1:0] sym_wide;

  assign symbols.ready = advance;

  // a code outside the alphabet passes as already found, leaving the list alone
  assign sym_ok   = (int'(symbols.symbol) < ALPHABET_SIZE);
  assign sym_wide = {SYM_W'(0), symbols.symbol};

  assign ctrl[0].valid = symbols.valid;
  assign ctrl[0].last  = symbols.last_of_message;
  assign ctrl[0].found = !sym_ok;
  assign ctrl[0].rank  = '0;
  assign sym[0]        = sym_wide[SYM_W-1:0];
  assign carry[0]      = sym_wide[SYM_W-1:0];

  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
    mtf_cell #(
      .SYM_W (SYM_W),
      .INDEX (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .ctrl_in   (ctrl[k]),
      .sym_in    (sym[k]),
      .carry_in  (carry[k]),
      .ctrl_out  (ctrl[k+1]),
      .sym_out   (sym[k+1]),
      .carry_out (carry[k+1])
    );
  end

  mtf_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && ctrl[ALPHABET_SIZE].valid),
    .push_rank (ctrl[ALPHABET_SIZE].rank),
    .room      (advance),
    .ranks     (ranks)
  );

endmodule

`default_nettype wire

// ===== verif/move_to_front_encoder_test.sv =====
// move_to_front_encoder_test: self-checking bench for the move-to-front encoder.
// Depends on mtf_pkg, mtf_sym_if/mtf_rank_if and move_to_front_encoder.
module move_to_front_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYMBOL_W      = mtf_pkg::SYMBOL_W;
  localparam int RANK_W        = mtf_pkg::RANK_W;
  localparam int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  logic clk;
  logic rst;

  mtf_sym_if  symbols();
  mtf_rank_if ranks();

  move_to_front_encoder #(.ALPHABET_SIZE(ALPHABET_SIZE)) dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols),
    .ranks   (ranks)
  );

  // model state: symbol held at each list position
  int                mtf_order[ALPHABET_SIZE];
  logic [RANK_W-1:0] expected_ranks[$];
  logic [RANK_W-1:0] wanted_rank;
  int                fail_count;
  int                cycle_count;
  bit                idle_on;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void restore_order();
    for (int k = 0; k < ALPHABET_SIZE; k++) mtf_order[k] = k;
  endfunction

  // rank of sym in the current list, then move it to the front; restore identity order after the last symbol
  function automatic logic [RANK_W-1:0] encode_symbol(logic [SYMBOL_W-1:0] sym, logic last);
    int pos;
    bit found;
    pos   = 0;
    found = 1'b0;
    for (int k = 0; k < ALPHABET_SIZE; k++) begin
      if (!found && mtf_order[k] == int'(sym)) begin
        pos   = k;
        found = 1'b1;
      end
    end
    if (found) begin
      for (int k = pos; k > 0; k--) mtf_order[k] = mtf_order[k-1];
      mtf_order[0] = int'(sym);
    end
    if (last) restore_order();
    return pos[RANK_W-1:0];
  endfunction

  task automatic note_mismatch(string what, logic [RANK_W-1:0] want, logic [RANK_W-1:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch at %0t: %s expected rank %0d, got %0d", $realtime, what, want, got);
  endtask

  // one symbol transaction; called and returns at a falling edge
  task automatic send_symbol(logic [SYMBOL_W-1:0] sym, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      symbols.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    symbols.valid           <= 1'b1;
    symbols.symbol          <= sym;
    symbols.last_of_message <= last;
    do @(posedge clk); while (!(symbols.valid && symbols.ready));
    expected_ranks.push_back(encode_symbol(sym, last));
    @(negedge clk);
  endtask

  task automatic test_extremes();
    idle_on = 1'b0;
    send_symbol(7'd0, 1'b0);     // already in front
    send_symbol(7'd0, 1'b0);
    send_symbol(7'd127, 1'b0);   // deepest position
    send_symbol(7'd127, 1'b0);
    send_symbol(7'd0, 1'b0);
    send_symbol(7'd85, 1'b0);
    send_symbol(7'd42, 1'b0);
    send_symbol(7'd127, 1'b0);
    send_symbol(7'd1, 1'b1);     // end of message, list back to identity
    send_symbol(7'd127, 1'b0);
    send_symbol(7'd127, 1'b1);   // last on a symbol already in front
    send_symbol(7'd64, 1'b1);    // single-symbol message
    send_symbol(7'd63, 1'b0);
  endtask

  task automatic test_message_reset();
    idle_on = 1'b1;
    for (int n = 0; n < 4; n++) begin
      send_symbol(7'd10, 1'b0);
      send_symbol(7'd20, 1'b0);
      send_symbol(7'd10, n[0]);
    end
  endtask

  task automatic test_random_messages(int count);
    logic [SYMBOL_W-1:0] sym;
    logic [SYMBOL_W-1:0] prev;
    logic [SYMBOL_W-1:0] base;
    int sent;
    int len;
    int pick;
    sent = 0;
    prev = 7'd0;
    while (sent < count) begin
      // alternate stretches with and without idling
      idle_on = ($urandom_range(0, 3) != 0);
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      base    = SYMBOL_W'($urandom_range(0, 127));
      for (int k = 0; k < len && sent < count; k++) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) sym = base + SYMBOL_W'($urandom_range(0, 7));   // small working set
        else if (pick < 7) sym = prev;                                // repeat, rank 0 unless prev ended a message
        else sym = SYMBOL_W'($urandom_range(0, 127));
        send_symbol(sym, (k == len - 1));
        prev = sym;
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    for (int k = 0; k < count; k++)
      send_symbol(SYMBOL_W'($urandom_range(0, 127)), ($urandom_range(0, 15) == 0));
  endtask

  // result side back-pressure
  initial begin
    ranks.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        ranks.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      ranks.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && ranks.valid && ranks.ready) begin
      if (expected_ranks.size() == 0) begin
        note_mismatch("unexpected transaction,", 'x, ranks.rank);
      end else begin
        wanted_rank = expected_ranks.pop_front();
        if (ranks.rank !== wanted_rank) note_mismatch("rank", wanted_rank, ranks.rank);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL move_to_front_encoder");
      $finish;
    end
  end

  initial begin
    rst                     = 1'b1;
    symbols.valid           = 1'b0;
    symbols.symbol          = '0;
    symbols.last_of_message = 1'b0;
    idle_on                 = 1'b0;
    fail_count              = 0;
    cycle_count             = 0;
    restore_order();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_extremes();
    test_message_reset();
    test_random_messages(330);
    test_back_to_back(50);

    symbols.valid <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk);
    repeat (ALPHABET_SIZE + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS move_to_front_encoder");
    end else begin
      $display("FAIL move_to_front_encoder");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mtf_pkg.sv
design/mtf_if.sv
design/mtf_cell.sv
design/mtf_out_buf.sv
design/move_to_front_encoder.sv
verif/move_to_front_encoder_test.sv
